// ===== design/gdss_pkg.sv =====
// Package for the gated decaying slot store: word types, function codes,
// status codes and fixed-point constants. No dependencies.
package gdss_pkg;

    localparam int unsigned Q_ONE     = 16384;
    localparam int unsigned Q_TENTH   = 1638;
    localparam int unsigned GATE_LOW  = 1638;
    localparam int unsigned GATE_HIGH = 14746;
    localparam int unsigned NEUTRAL   = 8192;

    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_STORE    = 3'd1;
    localparam logic [2:0] FN_RETRIEVE = 3'd2;
    localparam logic [2:0] FN_REFRESH  = 3'd3;
    localparam logic [2:0] FN_CLEAR    = 3'd4;
    localparam logic [2:0] FN_MODULATE = 3'd5;
    localparam logic [2:0] FN_INHIBIT  = 3'd6;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_GATE   = 3'd1;
    localparam logic [2:0] ST_NOROOM = 3'd2;
    localparam logic [2:0] ST_BADIDX = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    localparam logic [2:0] CFG_SLOTS    = 3'd0;
    localparam logic [2:0] CFG_GATE     = 3'd1;
    localparam logic [2:0] CFG_DECAY    = 3'd2;
    localparam logic [2:0] CFG_CLIMIT   = 3'd3;
    localparam logic [2:0] CFG_IGAIN    = 3'd4;
    localparam logic [2:0] CFG_DGAIN    = 3'd5;
    localparam logic [2:0] CFG_CENABLE  = 3'd6;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  slot_index;
        logic [14:0] priority_req;
        logic [31:0] content_tag;
        logic [15:0] elapsed;
        logic [14:0] dopamine_in;
        logic [14:0] inhibit_level;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_taken;
        logic [31:0] tag_out;
        logic [14:0] activation_out;
        logic [4:0]  occupied_count;
        logic [14:0] mean_activation;
        logic [14:0] load_level;
        logic [14:0] conflict_value;
        logic        conflict_flag;
        logic [14:0] inhibition_value;
    } out_word_t;

endpackage

// ===== design/gdss_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module gdss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== design/gdss_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module gdss_div #(
    parameter int NW = 20,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign busy  = (cnt_reg != '0);
    assign quot  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_reg <= trial - {1'b0, d_reg};
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== design/gated_decaying_slot_store_top.sv =====
// Gated decaying slot store: top level with sequencer and slot table.
// Uses gdss_pkg, gdss_ram (tags) and gdss_div (mean and load).
// Per word: tick scans the slots in use and divides for mean and load; store scans
// for a free or weakest slot unless the gate is closed; retrieve, refresh and clear
// check the index, and retrieve then reads the tag.
// One word in flight; the next is taken in the cycle after the result is registered.
// Reset clears all slots at once (valid bits), gate to 8192, inhibition and
// conflict to zero, registers to their defaults. Tags are unset until stored.
module gated_decaying_slot_store_top #(
    parameter int SLOT_COUNT = 16,
    parameter int TAG_BITS   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gdss_pkg::in_word_t   in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gdss_pkg::out_word_t  out_word,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import gdss_pkg::*;

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW = $clog2(SLOT_COUNT + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DIVM  = 4'd3;
    localparam logic [3:0] S_DIVL  = 4'd4;
    localparam logic [3:0] S_INH   = 4'd5;
    localparam logic [3:0] S_STORE = 4'd6;
    localparam logic [3:0] S_IDX   = 4'd7;
    localparam logic [3:0] S_RDTAG = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_WAITM = 4'd10;
    localparam logic [3:0] S_WAITL = 4'd11;

    logic [4:0]  slots_reg;
    logic [14:0] gate_base_reg, climit_reg, igain_reg, dgain_reg;
    logic [15:0] decay_reg;
    logic        cen_reg;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [14:0] act_reg [SLOT_COUNT];
    logic [14:0] gate_reg, inh_reg, conf_reg;

    logic [3:0]    state_reg;
    in_word_t      req_reg;
    out_word_t     res_reg;
    out_word_t     out_reg;
    out_word_t     done_word;
    logic          out_valid_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] i_reg;
    logic [NW-1:0] occ_reg;
    logic [19:0]   sum_reg;
    logic [31:0]   prod_reg;
    logic          empty_reg;
    logic [15:0]   lowest_reg;
    logic [SW-1:0] target_reg;
    logic [14:0]   mean_reg, load_reg;

    logic [NW-1:0] n_live;
    assign n_live = (int'(slots_reg) > SLOT_COUNT) ? NW'(SLOT_COUNT) : NW'(slots_reg);

    // single shared multiplier
    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [14:0] dmag;
    logic        dneg;
    assign dneg = req_reg.dopamine_in < 15'(NEUTRAL);
    assign dmag = dneg ? 15'(NEUTRAL) - req_reg.dopamine_in
                       : req_reg.dopamine_in - 15'(NEUTRAL);

    always_comb
    begin
        mul_a = req_reg.elapsed;
        mul_b = decay_reg;
        case (state_reg)
            S_PREP:
            begin
                if (req_reg.func == FN_MODULATE)
                begin
                    mul_a = {1'b0, dmag};
                    mul_b = {1'b0, dgain_reg};
                end
                else if (req_reg.func == FN_INHIBIT)
                begin
                    mul_a = {1'b0, req_reg.inhibit_level};
                    mul_b = {1'b0, igain_reg};
                end
            end
            S_DIVL:
            begin
                mul_a = req_reg.elapsed;
                mul_b = 16'(Q_TENTH);
            end
            S_INH:
            begin
                mul_a = {1'b0, inh_reg};
                mul_b = (prod_reg[31:14] >= 18'(Q_ONE)) ? 16'd0
                        : 16'(Q_ONE) - prod_reg[29:14];
            end
            default: ;
        endcase
    end

    // divider for mean and load
    logic          div_start, div_busy;
    logic [19:0]   div_num, div_q;
    logic [NW-1:0] div_den;

    gdss_div #(.NW(20), .DW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_q)
    );

    always_comb
    begin
        div_start = 1'b0;
        div_num   = sum_reg;
        div_den   = occ_reg;
        if (state_reg == S_DIVM && occ_reg != '0)
        begin
            div_start = 1'b1;
        end
        if (state_reg == S_DIVL && n_reg != '0)
        begin
            div_start = 1'b1;
            div_num   = 20'(occ_reg) << 14;
            div_den   = n_reg;
        end
    end

    // tag memory
    logic                tag_we;
    logic [SW-1:0]       tag_addr;
    logic [TAG_BITS-1:0] tag_wdata, tag_rdata;

    gdss_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOT_COUNT)) u_tags (
        .clk   (clk),
        .we    (tag_we),
        .addr  (tag_addr),
        .wdata (tag_wdata),
        .rdata (tag_rdata)
    );

    logic [SW-1:0] idx_s;
    assign idx_s = SW'(req_reg.slot_index);
    assign tag_we = (state_reg == S_STORE) && !(n_reg == '0 || (!empty_reg
                    && {1'b0, req_reg.priority_req} < lowest_reg));
    assign tag_addr = (state_reg == S_STORE) ? target_reg : idx_s;
    assign tag_wdata = TAG_BITS'(req_reg.content_tag);

    logic [SW-1:0] i_s;
    assign i_s = SW'(i_reg);

    // retrieve: add 0.1, capped at 1.0
    logic [15:0] ret_sum;
    logic [14:0] ret_act;
    assign ret_sum = {1'b0, act_reg[idx_s]} + 16'(Q_TENTH);
    assign ret_act = (ret_sum > 16'(Q_ONE)) ? 15'(Q_ONE) : ret_sum[14:0];

    logic [NW-1:0] cnt_valid;
    always_comb
    begin
        cnt_valid = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            if (valid_reg[k] && NW'(k) < n_reg)
            begin
                cnt_valid = cnt_valid + 1'b1;
            end
        end
    end

    always_comb
    begin
        done_word                  = res_reg;
        done_word.occupied_count   = 5'(cnt_valid);
        done_word.conflict_value   = conf_reg;
        done_word.inhibition_value = inh_reg;
    end

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= 5'd7;
            gate_base_reg <= 15'd8192;
            decay_reg     <= 16'd1638;
            climit_reg    <= 15'd9830;
            igain_reg     <= 15'd13107;
            dgain_reg     <= 15'd8192;
            cen_reg       <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOTS:   slots_reg     <= cfg_data[4:0];
                CFG_GATE:    gate_base_reg <= cfg_data[14:0];
                CFG_DECAY:   decay_reg     <= cfg_data;
                CFG_CLIMIT:  climit_reg    <= cfg_data[14:0];
                CFG_IGAIN:   igain_reg     <= cfg_data[14:0];
                CFG_DGAIN:   dgain_reg     <= cfg_data[14:0];
                CFG_CENABLE: cen_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [15:0] eff;
    logic [16:0] gsum;
    always_comb
    begin
        eff  = 16'(prod_reg[31:14]);
        gsum = dneg ? 17'(gate_base_reg) + 17'(eff)
                    : ((17'(eff) > 17'(gate_base_reg)) ? 17'd0
                       : 17'(gate_base_reg) - 17'(eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                act_reg[k] <= '0;
            end
            gate_reg <= 15'd8192;
            inh_reg  <= '0;
            conf_reg <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        req_reg   <= in_word;
                        n_reg     <= n_live;
                        res_reg   <= '0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    prod_reg   <= mul_p;
                    i_reg      <= '0;
                    occ_reg    <= '0;
                    sum_reg    <= '0;
                    empty_reg  <= 1'b0;
                    lowest_reg <= 16'd32768;
                    target_reg <= '0;
                    mean_reg   <= '0;
                    load_reg   <= '0;
                    case (req_reg.func)
                        FN_TICK:  state_reg <= S_SCAN;
                        FN_STORE:
                        begin
                            if (req_reg.priority_req < gate_reg)
                            begin
                                res_reg.status <= ST_GATE;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        FN_RETRIEVE, FN_REFRESH, FN_CLEAR: state_reg <= S_IDX;
                        default:  state_reg <= S_INH;
                    endcase
                end
                S_SCAN:
                begin
                    if (i_reg == n_reg)
                    begin
                        state_reg <= (req_reg.func == FN_TICK) ? S_DIVM : S_STORE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (req_reg.func == FN_TICK)
                        begin
                            if (valid_reg[i_s])
                            begin
                                if ({3'd0, act_reg[i_s]} <= prod_reg[31:14])
                                begin
                                    valid_reg[i_s] <= 1'b0;
                                    act_reg[i_s]   <= '0;
                                end
                                else
                                begin
                                    act_reg[i_s] <= act_reg[i_s] - prod_reg[28:14];
                                    occ_reg <= occ_reg + 1'b1;
                                    sum_reg <= sum_reg + 20'(act_reg[i_s] - prod_reg[28:14]);
                                end
                            end
                        end
                        else if (!valid_reg[i_s])
                        begin
                            target_reg <= i_s;
                            empty_reg  <= 1'b1;
                            state_reg  <= S_STORE;
                        end
                        else if ({1'b0, act_reg[i_s]} < lowest_reg)
                        begin
                            lowest_reg <= {1'b0, act_reg[i_s]};
                            target_reg <= i_s;
                        end
                    end
                end
                S_DIVM:   state_reg <= S_WAITM;
                S_WAITM:
                begin
                    if (!div_busy)
                    begin
                        mean_reg  <= (occ_reg != '0) ? div_q[14:0] : '0;
                        state_reg <= S_DIVL;
                    end
                end
                S_DIVL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_WAITL;
                end
                S_WAITL:
                begin
                    if (!div_busy)
                    begin
                        load_reg  <= (n_reg != '0) ? div_q[14:0] : '0;
                        state_reg <= S_INH;
                        if (cen_reg)
                        begin
                            conf_reg <= (n_reg != '0 && div_q[15:1] > 15'(inh_reg >> 1))
                                        ? div_q[15:1] : 15'(inh_reg >> 1);
                        end
                    end
                end
                S_INH:
                begin
                    case (req_reg.func)
                        FN_TICK: inh_reg <= mul_p[28:14];
                        FN_MODULATE:
                            gate_reg <= (gsum < 17'(GATE_LOW)) ? 15'(GATE_LOW)
                                      : (gsum > 17'(GATE_HIGH)) ? 15'(GATE_HIGH)
                                      : gsum[14:0];
                        FN_INHIBIT:
                        begin
                            if (prod_reg[31:14] > 18'(Q_ONE) || (prod_reg[31:14] > 18'(inh_reg)
                                && prod_reg[31:14] == 18'(Q_ONE)))
                            begin
                                inh_reg <= 15'(Q_ONE);
                            end
                            else if (prod_reg[31:14] > 18'(inh_reg))
                            begin
                                inh_reg <= prod_reg[28:14];
                            end
                            else if (inh_reg > 15'(Q_ONE))
                            begin
                                inh_reg <= 15'(Q_ONE);
                            end
                        end
                        default: ;
                    endcase
                    if (req_reg.func == FN_TICK)
                    begin
                        res_reg.mean_activation <= mean_reg;
                        res_reg.load_level      <= load_reg;
                        res_reg.conflict_flag   <= cen_reg && (conf_reg > climit_reg);
                    end
                    state_reg <= S_DONE;
                end
                S_STORE:
                begin
                    if (tag_we)
                    begin
                        valid_reg[target_reg]  <= 1'b1;
                        act_reg[target_reg]    <= req_reg.priority_req;
                        res_reg.slot_taken     <= 4'(target_reg);
                    end
                    else
                    begin
                        res_reg.status <= ST_NOROOM;
                    end
                    state_reg <= S_DONE;
                end
                S_IDX:
                begin
                    if (NW'(req_reg.slot_index) >= n_reg)
                    begin
                        res_reg.status <= ST_BADIDX;
                        state_reg      <= S_DONE;
                    end
                    else if (req_reg.func == FN_CLEAR)
                    begin
                        valid_reg[idx_s] <= 1'b0;
                        act_reg[idx_s]   <= '0;
                        state_reg        <= S_DONE;
                    end
                    else if (!valid_reg[idx_s])
                    begin
                        res_reg.status <= ST_EMPTY;
                        state_reg      <= S_DONE;
                    end
                    else if (req_reg.func == FN_RETRIEVE)
                    begin
                        act_reg[idx_s]         <= ret_act;
                        res_reg.activation_out <= ret_act;
                        state_reg              <= S_RDTAG;
                    end
                    else
                    begin
                        act_reg[idx_s]         <= 15'(Q_ONE);
                        res_reg.activation_out <= 15'(Q_ONE);
                        state_reg              <= S_DONE;
                    end
                end
                S_RDTAG:
                begin
                    res_reg.tag_out <= 32'(tag_rdata);
                    state_reg       <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg   <= done_word;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("accept while busy");
    a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (gate_reg >= 15'(GATE_LOW) && gate_reg <= 15'(GATE_HIGH)))
        else $error("gate");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
        else $error("stalled word changed");
    a_inh_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (inh_reg <= 15'(Q_ONE) || $past(inh_reg) > 15'(Q_ONE)))
        else $error("inhibition above one");
`endif
endmodule
